// ===== rtl/ttt_pkg.sv =====
// ----------------------------------------------------------------------------
// ttt_pkg: shared types and helpers of the template tag tokenizer
// Token codes, item and result records, byte classes, length saturation.
// ----------------------------------------------------------------------------
package ttt_pkg;

    localparam int POS_BITS = 32;
    localparam int LEN_BITS = 16;

    localparam logic [3:0] K_START  = 4'd0;
    localparam logic [3:0] K_SPACE  = 4'd1;
    localparam logic [3:0] K_END    = 4'd2;
    localparam logic [3:0] K_INT    = 4'd3;
    localparam logic [3:0] K_NUM    = 4'd4;
    localparam logic [3:0] K_WORD   = 4'd5;
    localparam logic [3:0] K_SQ     = 4'd6;
    localparam logic [3:0] K_DQ     = 4'd7;
    localparam logic [3:0] K_BAD    = 4'd8;
    localparam logic [3:0] K_UNTERM = 4'd9;
    localparam logic [3:0] K_DONE   = 4'd10;

    localparam logic [1:0] CFG_END_FIRST  = 2'd0;
    localparam logic [1:0] CFG_END_SECOND = 2'd1;
    localparam logic [1:0] CFG_OPEN_LEN   = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [LEN_BITS-1:0] t_len;

    typedef struct packed {
        logic [7:0] end_first;
        logic [7:0] end_second;
        logic [3:0] open_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       last;
        t_pos       base;
        t_pos       pos;
    } t_item;

    typedef struct packed {
        logic [3:0] kind;
        t_pos       pos;
        t_len       len;
        logic       fin;
    } t_res;

    typedef struct packed {
        logic [2:0] wq_n;
        logic [1:0] ob_n;
        logic       ob_k;
    } t_stat;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h37;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_e(input logic [7:0] c);
        return c == 8'h65 || c == 8'h45;
    endfunction

    function automatic logic is_p(input logic [7:0] c);
        return c == 8'h70 || c == 8'h50;
    endfunction

    function automatic logic is_x(input logic [7:0] c);
        return c == 8'h78 || c == 8'h58;
    endfunction

    // clamp a position difference to the length field
    function automatic t_len sat_len(input t_pos v);
        logic [POS_BITS+LEN_BITS-1:0] w;
        logic [POS_BITS+LEN_BITS-1:0] lim;
        w   = (POS_BITS+LEN_BITS)'(v);
        lim = (POS_BITS+LEN_BITS)'({LEN_BITS{1'b1}});
        return (w > lim) ? {LEN_BITS{1'b1}} : LEN_BITS'(w);
    endfunction

endpackage

// ===== rtl/ttt_front.sv =====
// ----------------------------------------------------------------------------
// ttt_front: input side of the tokenizer
// Takes byte transfers, numbers each byte within its tag, queues the item.
// ----------------------------------------------------------------------------
module ttt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [7:0]       i_ch,
    input  logic             i_first,
    input  logic             i_last,
    input  ttt_pkg::t_pos    i_base_pos,
    input  logic             i_q_full,
    output logic             o_q_wr,
    output ttt_pkg::t_item   o_q_item
);
    import ttt_pkg::*;

    t_pos r_cur_pos;
    t_pos n_cur_pos;

    always_comb begin
        o_q_wr         = i_push & ~i_q_full;
        o_q_item.ch    = i_ch;
        o_q_item.first = i_first;
        o_q_item.last  = i_last;
        o_q_item.base  = i_base_pos;
        o_q_item.pos   = i_first ? '0 : r_cur_pos;
        n_cur_pos      = o_q_wr ? o_q_item.pos + t_pos'(1) : r_cur_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_pos <= '0;
        end else begin
            r_cur_pos <= n_cur_pos;
        end
    end

endmodule

// ===== rtl/ttt_fifo.sv =====
// ----------------------------------------------------------------------------
// ttt_fifo: two-entry item queue
// Decouples byte intake from the scanner.
// ----------------------------------------------------------------------------
module ttt_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  ttt_pkg::t_item   i_item,
    input  logic             i_rd,
    output ttt_pkg::t_item   o_item,
    output logic             o_full,
    output logic             o_empty
);
    import ttt_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
    end

endmodule

// ===== rtl/ttt_scan.sv =====
// ----------------------------------------------------------------------------
// ttt_scan: tokenizer back end
// Feeds one byte a cycle (while results have room) through the scan state
// machine, replays held lookahead bytes, and drains a two-entry output buffer.
// ----------------------------------------------------------------------------
module ttt_scan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ttt_pkg::t_cfg    i_cfg,
    input  ttt_pkg::t_item   i_item,
    input  logic             i_q_empty,
    output logic             o_q_rd,
    output ttt_pkg::t_res    o_res,
    output logic             o_empty,
    input  logic             i_pop,
    output ttt_pkg::t_stat   o_stat
);
    import ttt_pkg::*;

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_GAP   = 3'd1;
    localparam logic [2:0] M_SPACE = 3'd2;
    localparam logic [2:0] M_WORD  = 3'd3;
    localparam logic [2:0] M_NUM   = 3'd4;
    localparam logic [2:0] M_SQ    = 3'd5;
    localparam logic [2:0] M_DQ    = 3'd6;
    localparam logic [2:0] M_ENDQ  = 3'd7;

    localparam logic [3:0] P_ZERO  = 4'd0;
    localparam logic [3:0] P_ZX    = 4'd1;
    localparam logic [3:0] P_DEC   = 4'd2;
    localparam logic [3:0] P_OCT   = 4'd3;
    localparam logic [3:0] P_HEX   = 4'd4;
    localparam logic [3:0] P_DOT   = 4'd5;
    localparam logic [3:0] P_HDOT  = 4'd6;
    localparam logic [3:0] P_FRAC  = 4'd7;
    localparam logic [3:0] P_HFRAC = 4'd8;
    localparam logic [3:0] P_EXP1  = 4'd9;
    localparam logic [3:0] P_EXP2  = 4'd10;
    localparam logic [3:0] P_EXPD  = 4'd11;

    localparam logic [1:0] A_POP    = 2'd0;
    localparam logic [1:0] A_RESCAN = 2'd1;
    localparam logic [1:0] A_CLEAR  = 2'd2;

    // scan state
    logic [2:0] r_mode,  n_mode;
    logic [3:0] r_phase, n_phase;
    logic [1:0] r_pend,  n_pend;
    logic [7:0] r_held [2];
    logic [7:0] n_held [2];
    logic       r_stop,  n_stop;
    t_pos       r_ts,    n_ts;
    t_pos       r_org,   n_org;

    // work queue of bytes for the current item
    logic [7:0] r_wq [4];
    logic [7:0] n_wq [4];
    logic [2:0] r_wq_n,  n_wq_n;
    t_pos       r_w_pos, n_w_pos;
    logic       r_w_start, n_w_start;
    t_pos       r_w_base,  n_w_base;

    // output buffer
    t_res       r_ob [2];
    t_res       n_ob [2];
    logic [1:0] r_ob_n, n_ob_n;
    logic       r_ob_k, n_ob_k;

    // begin-token decode
    logic [7:0] bb;
    t_pos       bidx, bidx1;
    logic       ball;
    logic [2:0] bg_mode;
    logic [3:0] bg_phase;
    logic       bg_e0, bg_len1, bg_fin, bg_inc;
    logic [3:0] bg_kind;

    logic [7:0] b;
    t_pos       idx, idx1;
    logic       e0_v, fin_v;
    logic [3:0] e0_kind;
    t_pos       e0_ts, e0_end, fin_stop;
    logic [1:0] act;
    logic       st_start, st_drop, go, ob_free;
    logic [1:0] step_cnt;
    t_res       res0, resd, res_start;
    logic [7:0] qsel;

    assign b    = r_wq[0];
    assign idx  = r_w_pos;
    assign idx1 = r_w_pos + t_pos'(1);

    // token start decode, shared by the gap state and a failed end match
    always_comb begin
        bb    = (r_mode == M_ENDQ) ? i_cfg.end_first : b;
        bidx  = (r_mode == M_ENDQ) ? r_ts : idx;
        bidx1 = bidx + t_pos'(1);
        ball  = (r_mode != M_ENDQ);
        bg_mode  = r_mode;
        bg_phase = r_phase;
        bg_e0    = 1'b0;
        bg_kind  = K_BAD;
        bg_len1  = 1'b0;
        bg_fin   = 1'b0;
        bg_inc   = 1'b0;
        if (bb == CH_NUL) begin
            bg_fin  = 1'b1;
            bg_mode = M_GAP;
        end else if (is_space(bb)) begin
            bg_mode = M_SPACE;
        end else if (ball && i_cfg.end_first == CH_NUL) begin
            bg_e0   = 1'b1;
            bg_kind = K_END;
            bg_fin  = 1'b1;
            bg_mode = M_GAP;
        end else if (ball && bb == i_cfg.end_first) begin
            if (i_cfg.end_second == CH_NUL) begin
                bg_e0   = 1'b1;
                bg_kind = K_END;
                bg_len1 = 1'b1;
                bg_fin  = 1'b1;
                bg_inc  = 1'b1;
                bg_mode = M_GAP;
            end else begin
                bg_mode = M_ENDQ;
            end
        end else if (is_digit(bb)) begin
            bg_mode  = M_NUM;
            bg_phase = (bb == CH_ZERO) ? P_ZERO : P_DEC;
        end else if (is_alpha(bb)) begin
            bg_mode = M_WORD;
        end else if (bb == CH_SQ) begin
            bg_mode = M_SQ;
        end else if (bb == CH_DQ) begin
            bg_mode = M_DQ;
        end else begin
            bg_e0   = 1'b1;
            bg_kind = K_BAD;
            bg_len1 = 1'b1;
            bg_fin  = 1'b1;
            bg_mode = M_GAP;
        end
    end

    // one scan step on the head byte
    always_comb begin
        logic hold;
        logic [3:0] hold_ph;
        logic close;
        logic [3:0] close_kind;
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_pend   = r_pend;
        n_held   = r_held;
        n_ts     = r_ts;
        e0_v     = 1'b0;
        e0_kind  = K_BAD;
        e0_ts    = r_ts;
        e0_end   = idx;
        fin_v    = 1'b0;
        fin_stop = idx;
        act      = A_POP;
        hold     = 1'b0;
        hold_ph  = r_phase;
        close    = 1'b0;
        close_kind = K_INT;
        qsel     = (r_mode == M_SQ) ? CH_SQ : CH_DQ;
        case (r_mode)
            M_GAP: begin
                n_mode   = bg_mode;
                n_phase  = bg_phase;
                n_ts     = idx;
                n_pend   = 2'd0;
                e0_v     = bg_e0;
                e0_kind  = bg_kind;
                e0_ts    = idx;
                e0_end   = bg_len1 ? bidx1 : bidx;
                fin_v    = bg_fin;
                fin_stop = bg_inc ? bidx1 : bidx;
            end
            M_SPACE: begin
                if (!is_space(b)) begin
                    e0_v = 1'b1; e0_kind = K_SPACE; n_mode = M_GAP; act = A_RESCAN;
                end
            end
            M_WORD: begin
                if (!(is_alpha(b) || is_digit(b))) begin
                    e0_v = 1'b1; e0_kind = K_WORD; n_mode = M_GAP; act = A_RESCAN;
                end
            end
            M_SQ, M_DQ: begin
                if (b == qsel) begin
                    e0_v    = 1'b1;
                    e0_kind = (r_mode == M_SQ) ? K_SQ : K_DQ;
                    e0_end  = idx1;
                    n_mode  = M_GAP;
                end else if (b == CH_NUL) begin
                    e0_v = 1'b1; e0_kind = K_UNTERM; n_mode = M_GAP; act = A_RESCAN;
                end
            end
            M_ENDQ: begin
                if (b == i_cfg.end_second) begin
                    e0_v     = 1'b1;
                    e0_kind  = K_END;
                    e0_end   = idx1;
                    fin_v    = 1'b1;
                    fin_stop = idx1;
                    n_mode   = M_GAP;
                end else begin
                    // the delimiter byte starts a token of its own
                    n_mode   = bg_mode;
                    n_phase  = bg_phase;
                    n_pend   = 2'd0;
                    e0_v     = bg_e0;
                    e0_kind  = bg_kind;
                    e0_end   = bg_len1 ? bidx1 : bidx;
                    fin_v    = bg_fin;
                    fin_stop = bg_inc ? bidx1 : bidx;
                    act      = A_RESCAN;
                end
            end
            M_NUM: begin
                case (r_phase)
                    P_ZERO: begin
                        if (is_x(b)) begin
                            hold = 1'b1; hold_ph = P_ZX;
                        end else if (is_oct(b)) begin
                            n_phase = P_OCT;
                        end else if (b == CH_DOT) begin
                            hold = 1'b1; hold_ph = P_DOT;
                        end else if (is_e(b)) begin
                            hold = 1'b1; hold_ph = P_EXP1;
                        end else begin
                            close = 1'b1;
                        end
                    end
                    P_ZX: begin
                        if (is_hex(b)) begin
                            n_pend = 2'd0; n_phase = P_HEX;
                        end else begin
                            close = 1'b1;
                        end
                    end
                    P_DEC, P_OCT: begin
                        if ((r_phase == P_DEC) ? is_digit(b) : is_oct(b)) begin
                            n_phase = r_phase;
                        end else if (b == CH_DOT) begin
                            hold = 1'b1; hold_ph = P_DOT;
                        end else if (is_e(b)) begin
                            hold = 1'b1; hold_ph = P_EXP1;
                        end else begin
                            close = 1'b1;
                        end
                    end
                    P_HEX: begin
                        if (is_hex(b)) begin
                            n_phase = P_HEX;
                        end else if (b == CH_DOT) begin
                            hold = 1'b1; hold_ph = P_HDOT;
                        end else begin
                            close = 1'b1;
                        end
                    end
                    P_DOT, P_HDOT: begin
                        if (is_digit(b)) begin
                            n_phase = (r_phase == P_DOT) ? P_FRAC : P_HFRAC;
                            n_pend  = 2'd0;
                        end else begin
                            close = 1'b1;
                        end
                    end
                    P_FRAC: begin
                        if (is_digit(b)) begin
                            n_phase = P_FRAC;
                        end else if (is_e(b)) begin
                            hold = 1'b1; hold_ph = P_EXP1;
                        end else begin
                            close = 1'b1; close_kind = K_NUM;
                        end
                    end
                    P_HFRAC: begin
                        if (is_hex(b)) begin
                            n_phase = P_HFRAC;
                        end else if (is_p(b)) begin
                            hold = 1'b1; hold_ph = P_EXP1;
                        end else begin
                            close = 1'b1; close_kind = K_NUM;
                        end
                    end
                    P_EXP1, P_EXP2: begin
                        if (is_digit(b)) begin
                            n_pend = 2'd0; n_phase = P_EXPD;
                        end else if (r_phase == P_EXP1 && (b == CH_PLUS || b == CH_MINUS)) begin
                            hold = 1'b1; hold_ph = P_EXP2;
                        end else begin
                            close = 1'b1; close_kind = K_NUM;
                        end
                    end
                    default: begin
                        if (!is_digit(b)) begin
                            close = 1'b1; close_kind = K_NUM;
                        end
                    end
                endcase
                if (hold) begin
                    if (r_pend < 2'd2) begin
                        n_held[r_pend[0]] = b;
                        n_pend = r_pend + 2'd1;
                    end
                    n_phase = hold_ph;
                end
                if (close) begin
                    e0_v    = 1'b1;
                    e0_kind = close_kind;
                    e0_end  = idx - t_pos'(r_pend);
                    n_mode  = M_GAP;
                    act     = A_RESCAN;
                end
            end
            default: begin
                act = A_CLEAR;
            end
        endcase
        if (act == A_RESCAN) begin
            n_pend = 2'd0;
        end
        if (fin_v) begin
            act = A_CLEAR;
        end
    end

    always_comb begin
        res0.kind = e0_kind;
        res0.pos  = r_org + e0_ts;
        res0.len  = sat_len(e0_end - e0_ts);
        res0.fin  = 1'b0;
        resd.kind = K_DONE;
        resd.pos  = r_org + fin_stop;
        resd.len  = sat_len(fin_stop);
        resd.fin  = 1'b1;
        res_start.kind = K_START;
        res_start.pos  = r_w_base;
        res_start.len  = LEN_BITS'(i_cfg.open_length);
        res_start.fin  = 1'b0;
    end

    assign st_start = r_w_start;
    assign st_drop  = ~r_w_start & ((r_mode == M_IDLE) | r_stop);
    assign step_cnt = st_start ? 2'd1 : (st_drop ? 2'd0 : 2'(e0_v) + 2'(fin_v));
    assign o_empty  = (r_ob_n == 2'd0);
    assign o_res    = r_ob[r_ob_k];
    assign ob_free  = o_empty | (i_pop & (r_ob_n == 2'(r_ob_k) + 2'd1));
    assign go       = (r_wq_n != 3'd0) & (ob_free | (step_cnt == 2'd0));

    always_comb begin
        n_org     = r_org;
        n_stop    = r_stop;
        n_wq      = r_wq;
        n_wq_n    = r_wq_n;
        n_w_pos   = r_w_pos;
        n_w_start = r_w_start;
        n_w_base  = r_w_base;
        n_ob      = r_ob;
        n_ob_n    = r_ob_n;
        n_ob_k    = r_ob_k;
        o_q_rd    = 1'b0;
        // result transfer
        if (i_pop && !o_empty) begin
            if (r_ob_n == 2'(r_ob_k) + 2'd1) begin
                n_ob_n = 2'd0;
                n_ob_k = 1'b0;
            end else begin
                n_ob_k = 1'b1;
            end
        end
        if (go) begin
            if (st_start) begin
                n_w_start = 1'b0;
                n_org     = r_w_base + t_pos'(i_cfg.open_length);
                n_stop    = 1'b0;
                n_ob[0]   = res_start;
            end else if (st_drop) begin
                n_wq_n = 3'd0;
            end else begin
                n_stop = fin_v;
                // a step without results may run while the buffer still drains
                if (e0_v) begin
                    n_ob[0] = res0;
                    n_ob[1] = resd;
                end else if (fin_v) begin
                    n_ob[0] = resd;
                end
                case (act)
                    A_POP: begin
                        n_wq[0] = r_wq[1];
                        n_wq[1] = r_wq[2];
                        n_wq[2] = r_wq[3];
                        n_wq_n  = r_wq_n - 3'd1;
                        n_w_pos = idx1;
                    end
                    A_RESCAN: begin
                        if (r_pend == 2'd2) begin
                            n_wq[0] = r_held[0];
                            n_wq[1] = r_held[1];
                            n_wq[2] = r_wq[0];
                            n_wq[3] = r_wq[1];
                        end else if (r_pend == 2'd1) begin
                            n_wq[0] = r_held[0];
                            n_wq[1] = r_wq[0];
                            n_wq[2] = r_wq[1];
                            n_wq[3] = r_wq[2];
                        end
                        n_wq_n  = r_wq_n + 3'(r_pend);
                        n_w_pos = idx - t_pos'(r_pend);
                    end
                    default: begin
                        n_wq_n = 3'd0;
                    end
                endcase
            end
            if (step_cnt != 2'd0) begin
                n_ob_n = step_cnt;
                n_ob_k = 1'b0;
            end
        end
        // next item enters as the current one runs out
        if (n_wq_n == 3'd0 && !i_q_empty) begin
            o_q_rd    = 1'b1;
            n_wq[0]   = i_item.ch;
            n_wq[1]   = CH_NUL;
            n_wq_n    = i_item.last ? 3'd2 : 3'd1;
            n_w_pos   = i_item.pos;
            n_w_start = i_item.first;
            n_w_base  = i_item.base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && !st_start && !st_drop) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_held  <= n_held;
            r_ts    <= n_ts;
        end else if (go && st_start) begin
            r_phase <= P_ZERO;
            r_pend  <= 2'd0;
            r_ts    <= '0;
        end
        r_wq     <= n_wq;
        r_w_pos  <= n_w_pos;
        r_w_base <= n_w_base;
        r_ob     <= n_ob;
        r_org    <= n_org;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_stop    <= 1'b0;
            r_wq_n    <= 3'd0;
            r_w_start <= 1'b0;
            r_ob_n    <= 2'd0;
            r_ob_k    <= 1'b0;
        end else begin
            if (go && st_start) begin
                r_mode <= M_GAP;
            end else if (go && !st_drop) begin
                r_mode <= n_mode;
            end
            r_stop    <= n_stop;
            r_wq_n    <= n_wq_n;
            r_w_start <= n_w_start;
            r_ob_n    <= n_ob_n;
            r_ob_k    <= n_ob_k;
        end
    end

    assign o_stat.wq_n = r_wq_n;
    assign o_stat.ob_n = r_ob_n;
    assign o_stat.ob_k = r_ob_k;

endmodule

// ===== rtl/template_tag_tokenizer.sv =====
// ----------------------------------------------------------------------------
// template_tag_tokenizer: byte-stream tokenizer for template tag bodies
// Queue-style byte input, queue-style token output, plain config writes.
// ----------------------------------------------------------------------------
// Takes one byte per cycle into a two-entry queue unless it is full. The
// scanner's step unit handles one byte a cycle unless held by a full output
// buffer; a first byte adds a step for the tag-start token and a last byte
// adds a step for the end of text. A byte that closes a space, word, number
// or unterminated-quote token, or that breaks a pending end delimiter, takes
// a second pass, and a failed lookahead replays its held bytes (up to two)
// ahead of it at one byte a cycle when not held. Results leave one per cycle
// from a two-entry output buffer; a step that yields results waits while it
// is occupied. Config must be written by the user while idle; unchecked.
module template_tag_tokenizer (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              i_ch,
    input  logic                    i_first,
    input  logic                    i_last,
    input  logic [ttt_pkg::POS_BITS-1:0] i_base_pos,
    output logic                    empty,
    input  logic                    pop,
    output logic [3:0]              o_token_kind,
    output logic [ttt_pkg::POS_BITS-1:0] o_token_pos,
    output logic [ttt_pkg::LEN_BITS-1:0] o_token_len,
    output logic                    o_final_res,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [7:0]              i_cfg_data
);
    import ttt_pkg::*;

    t_cfg  r_cfg;
    t_item q_wr_item, q_rd_item;
    logic  q_wr, q_rd, q_empty;
    t_res  res;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.end_first   <= 8'd37;
            r_cfg.end_second  <= 8'd93;
            r_cfg.open_length <= 4'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_END_FIRST:  r_cfg.end_first   <= i_cfg_data;
                CFG_END_SECOND: r_cfg.end_second  <= i_cfg_data;
                CFG_OPEN_LEN:   r_cfg.open_length <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    ttt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_ch       (i_ch),
        .i_first    (i_first),
        .i_last     (i_last),
        .i_base_pos (i_base_pos),
        .i_q_full   (full),
        .o_q_wr     (q_wr),
        .o_q_item   (q_wr_item)
    );

    ttt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (q_wr_item),
        .i_rd    (q_rd),
        .o_item  (q_rd_item),
        .o_full  (full),
        .o_empty (q_empty)
    );

    ttt_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_item    (q_rd_item),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .o_res     (res),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_stat    (stat)
    );

    assign o_token_kind = res.kind;
    assign o_token_pos  = res.pos;
    assign o_token_len  = res.len;
    assign o_final_res  = res.fin;

`ifndef SYNTHESIS
    a_fin_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_final_res) |-> (o_token_kind == K_DONE))
        else $error("final result without done kind");

    a_wq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.wq_n <= 3'd4)
        else $error("scan work queue overflow");

    a_ob_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.ob_n <= 2'd2) && (stat.ob_n == 2'd0 || 2'(stat.ob_k) < stat.ob_n))
        else $error("output buffer index out of range");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_final_res) |=> (stat.ob_n <= 2'd1))
        else $error("result queued behind a done result");
`endif

endmodule

// ===== tb/template_tag_tokenizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// template_tag_tokenizer_tb: self-checking bench for the tag tokenizer
// Feeds tag bodies byte by byte, some directed and some built from random
// well-formed token fragments with some noise. A built-in scanner model
// predicts every token. Results are compared in order, with random stalls
// on both sides and delimiter and open-length settings changed between tests.
// ----------------------------------------------------------------------------
module template_tag_tokenizer_tb;
    import ttt_pkg::*;

    localparam int LAT_WAIT = 24;
    localparam int WDOG_LIMIT = 4000;

    typedef enum logic [3:0] {
        SM_IDLE, SM_GAP, SM_SPACE, SM_WORD, SM_NUM, SM_SQ, SM_DQ, SM_ENDQ
    } t_scan;
    typedef enum logic [3:0] {
        NP_ZERO, NP_ZX, NP_DEC, NP_OCT, NP_HEX, NP_DOT, NP_HDOT, NP_FRAC,
        NP_HFRAC, NP_EXP1, NP_EXP2, NP_EXPD
    } t_nphase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_ch = '0;
    logic        i_first = 1'b0;
    logic        i_last = 1'b0;
    t_pos        i_base_pos = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_token_kind;
    t_pos        o_token_pos;
    t_len        o_token_len;
    logic        o_final_res;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;

    template_tag_tokenizer dut (.*);

    always #6 i_clk = ~i_clk;

    // scanner model state
    logic [7:0]  cf_end1 = 8'd37, cf_end2 = 8'd93;
    logic [3:0]  cf_open = 4'd2;
    t_scan       sc_mode = SM_IDLE;
    t_nphase     sc_phase = NP_ZERO;
    int unsigned sc_pend = 0;
    bit          sc_stopped = 0;
    logic [63:0] sc_origin = 0, sc_pos = 0, sc_tstart = 0;
    logic [7:0]  sc_held [2];
    int          step_n;

    t_res        token_q[$];
    int          send_idle = 0, recv_idle = 0;
    int          n_errors = 0, n_items = 0, n_tokens = 0, n_scans = 0;
    int          quiet = 0;
    logic [7:0]  frag[$];

    function automatic bit c_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic bit c_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit c_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit c_hexd(logic [7:0] c);
        return c_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic void add_token(logic [3:0] kind, logic [63:0] pos,
                                      logic [63:0] len, bit fin);
        t_res r;
        if (step_n >= 4) return;
        r.kind = kind;
        r.pos = pos[POS_BITS-1:0];
        r.len = (len > 64'hffff) ? 16'hffff : len[15:0];
        r.fin = fin;
        token_q.push_back(r);
        step_n++;
    endfunction

    function automatic void close_tok(logic [3:0] kind, logic [63:0] end_idx);
        add_token(kind, sc_origin + sc_tstart, end_idx - sc_tstart, 0);
    endfunction

    function automatic void stop_scan(logic [63:0] idx);
        add_token(K_DONE, sc_origin + idx, idx, 1);
        sc_stopped = 1;
        sc_mode = SM_GAP;
    endfunction

    function automatic void open_tok(logic [7:0] b, logic [63:0] idx, bit allow_end);
        sc_tstart = idx;
        sc_pend = 0;
        if (b == CH_NUL) stop_scan(idx);
        else if (c_space(b)) sc_mode = SM_SPACE;
        else if (allow_end && cf_end1 == 0) begin
            close_tok(K_END, idx);
            stop_scan(idx);
        end else if (allow_end && b == cf_end1) begin
            if (cf_end2 == 0) begin
                close_tok(K_END, idx + 1);
                stop_scan(idx + 1);
            end else sc_mode = SM_ENDQ;
        end else if (c_digit(b)) begin
            sc_mode = SM_NUM;
            sc_phase = (b == CH_ZERO) ? NP_ZERO : NP_DEC;
        end else if (c_alpha(b)) sc_mode = SM_WORD;
        else if (b == CH_SQ) sc_mode = SM_SQ;
        else if (b == CH_DQ) sc_mode = SM_DQ;
        else begin
            close_tok(K_BAD, idx + 1);
            stop_scan(idx);
        end
    endfunction

    function automatic void hold(logic [7:0] b, t_nphase ph);
        if (sc_pend < 2) begin
            sc_held[sc_pend] = b;
            sc_pend++;
        end
        sc_phase = ph;
    endfunction

    function automatic bit end_num(logic [3:0] kind, logic [63:0] idx);
        close_tok(kind, idx - sc_pend);
        sc_mode = SM_GAP;
        return 1;
    endfunction

    function automatic bit step_num(logic [7:0] b, logic [63:0] idx);
        bit e = (b == "e" || b == "E");
        case (sc_phase)
            NP_ZERO: begin
                if (b == "x" || b == "X") begin hold(b, NP_ZX); return 0; end
                if (b >= "0" && b <= "7") begin sc_phase = NP_OCT; return 0; end
                if (b == CH_DOT) begin hold(b, NP_DOT); return 0; end
                if (e) begin hold(b, NP_EXP1); return 0; end
                return end_num(K_INT, idx);
            end
            NP_ZX: begin
                if (c_hexd(b)) begin sc_pend = 0; sc_phase = NP_HEX; return 0; end
                return end_num(K_INT, idx);
            end
            NP_DEC, NP_OCT: begin
                if (sc_phase == NP_DEC ? c_digit(b) : (b >= "0" && b <= "7")) return 0;
                if (b == CH_DOT) begin hold(b, NP_DOT); return 0; end
                if (e) begin hold(b, NP_EXP1); return 0; end
                return end_num(K_INT, idx);
            end
            NP_HEX: begin
                if (c_hexd(b)) return 0;
                if (b == CH_DOT) begin hold(b, NP_HDOT); return 0; end
                return end_num(K_INT, idx);
            end
            NP_DOT, NP_HDOT: begin
                if (c_digit(b)) begin
                    sc_phase = (sc_phase == NP_DOT) ? NP_FRAC : NP_HFRAC;
                    sc_pend = 0;
                    return 0;
                end
                return end_num(K_INT, idx);
            end
            NP_FRAC: begin
                if (c_digit(b)) return 0;
                if (e) begin hold(b, NP_EXP1); return 0; end
                return end_num(K_NUM, idx);
            end
            NP_HFRAC: begin
                if (c_hexd(b)) return 0;
                if (b == "p" || b == "P") begin hold(b, NP_EXP1); return 0; end
                return end_num(K_NUM, idx);
            end
            NP_EXP1: begin
                if (c_digit(b)) begin sc_pend = 0; sc_phase = NP_EXPD; return 0; end
                if (b == CH_PLUS || b == CH_MINUS) begin hold(b, NP_EXP2); return 0; end
                return end_num(K_NUM, idx);
            end
            NP_EXP2: begin
                if (c_digit(b)) begin sc_pend = 0; sc_phase = NP_EXPD; return 0; end
                return end_num(K_NUM, idx);
            end
            default: begin
                if (c_digit(b)) return 0;
                return end_num(K_NUM, idx);
            end
        endcase
    endfunction

    // returns 1 when held bytes and b have to be rescanned
    function automatic bit step_byte(logic [7:0] b, logic [63:0] idx);
        case (sc_mode)
            SM_SPACE: begin
                if (c_space(b)) return 0;
                close_tok(K_SPACE, idx);
                sc_mode = SM_GAP;
                return 1;
            end
            SM_WORD: begin
                if (c_alpha(b) || c_digit(b)) return 0;
                close_tok(K_WORD, idx);
                sc_mode = SM_GAP;
                return 1;
            end
            SM_SQ, SM_DQ: begin
                if (b == (sc_mode == SM_SQ ? CH_SQ : CH_DQ)) begin
                    close_tok(sc_mode == SM_SQ ? K_SQ : K_DQ, idx + 1);
                    sc_mode = SM_GAP;
                    return 0;
                end
                if (b == CH_NUL) begin
                    close_tok(K_UNTERM, idx);
                    sc_mode = SM_GAP;
                    return 1;
                end
                return 0;
            end
            SM_ENDQ: begin
                if (b == cf_end2) begin
                    close_tok(K_END, idx + 1);
                    stop_scan(idx + 1);
                    return 0;
                end
                sc_mode = SM_GAP;
                open_tok(cf_end1, sc_tstart, 0);
                return 1;
            end
            SM_NUM: return step_num(b, idx);
            default: begin
                open_tok(b, idx, 1);
                return 0;
            end
        endcase
    endfunction

    function automatic void scan_byte(logic [7:0] b, logic [63:0] idx);
        logic [7:0]  qb[4], nb[4];
        logic [63:0] qi[4], ni[4];
        int qn = 1, i = 0, n, k;
        qb[0] = b;
        qi[0] = idx;
        while (i < qn && !sc_stopped) begin
            if (!step_byte(qb[i], qi[i])) begin
                i++;
            end else begin
                n = 0;
                for (k = 0; k < sc_pend && k < 2; k++) begin
                    nb[n] = sc_held[k];
                    ni[n] = qi[i] - sc_pend + k;
                    n++;
                end
                for (k = i; k < qn && n < 4; k++) begin
                    nb[n] = qb[k];
                    ni[n] = qi[k];
                    n++;
                end
                sc_pend = 0;
                for (k = 0; k < n; k++) begin
                    qb[k] = nb[k];
                    qi[k] = ni[k];
                end
                qn = n;
                i = 0;
            end
        end
    endfunction

    function automatic void predict_item(logic [7:0] b, bit first, bit last, t_pos base);
        step_n = 0;
        if (first) begin
            add_token(K_START, base, cf_open, 0);
            sc_origin = 64'(t_pos'(base + cf_open));
            sc_mode = SM_GAP;
            sc_phase = NP_ZERO;
            sc_pend = 0;
            sc_stopped = 0;
            sc_pos = 0;
            sc_tstart = 0;
            n_scans++;
        end else if (sc_mode == SM_IDLE || sc_stopped) begin
            return;
        end
        scan_byte(b, sc_pos);
        sc_pos++;
        if (last && !sc_stopped) scan_byte(CH_NUL, sc_pos);
    endfunction

    // ---------------- stimulus side ----------------
    task automatic send_byte(logic [7:0] b, bit first = 0, bit last = 0,
                             t_pos base = '0);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        i_ch = b;
        i_first = first;
        i_last = last;
        i_base_pos = base;
        do @(posedge i_clk); while (full);
        predict_item(b, first, last, base);
        n_items++;
    endtask

    task automatic send_text(string s, bit last, t_pos base);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k], k == 0, last && k == s.len() - 1, base);
    endtask

    task automatic drain();
        @(negedge i_clk);
        push = 1'b0;
        wait (token_q.size() == 0);
        repeat (LAT_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_END_FIRST:  cf_end1 = val;
            CFG_END_SECOND: cf_end2 = val;
            default:        cf_open = val[3:0];
        endcase
    endtask

    task automatic set_delims(logic [7:0] e1, logic [7:0] e2, logic [3:0] ol);
        drain();
        write_reg(CFG_END_FIRST, e1);
        write_reg(CFG_END_SECOND, e2);
        write_reg(CFG_OPEN_LEN, {4'd0, ol});
    endtask

    // one random token fragment into frag
    task automatic make_frag();
        int sel = $urandom_range(19);
        int n = $urandom_range(1, 4);
        frag.delete();
        case (sel)
            0, 1, 2: for (int k = 0; k < n; k++)
                frag.push_back(k == 0 || $urandom_range(2) ? 8'($urandom_range("a", "z"))
                                                           : 8'($urandom_range("0", "9")));
            3, 4: for (int k = 0; k < n; k++) frag.push_back(8'($urandom_range("0", "9")));
            5: begin
                frag = {"0", "x"};
                for (int k = 0; k < n - 1; k++) frag.push_back($urandom_range(1) ? "F" : "9");
            end
            6: begin
                frag.push_back("0");
                for (int k = 0; k < n; k++) frag.push_back(8'($urandom_range("0", "9")));
            end
            7, 8: begin
                frag = {"1", "."};
                if ($urandom_range(3)) frag.push_back(8'($urandom_range("0", "9")));
                if ($urandom_range(1)) frag.push_back($urandom_range(1) ? "e" : "E");
                if ($urandom_range(1)) frag.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                if ($urandom_range(2)) frag.push_back("7");
            end
            9: begin
                frag = {"7"};
                frag.push_back($urandom_range(1) ? "e" : "E");
                if ($urandom_range(1)) frag.push_back(CH_MINUS);
                if ($urandom_range(1)) frag.push_back("2");
            end
            10: begin
                frag = {"0", "x", "a", ".", "8"};
                if ($urandom_range(1)) frag.push_back("p");
                if ($urandom_range(1)) frag.push_back("3");
            end
            11, 12: begin
                frag.push_back($urandom_range(1) ? CH_SQ : CH_DQ);
                for (int k = 0; k < n; k++) frag.push_back(8'($urandom_range(32, 126)));
                if ($urandom_range(4)) frag.push_back(frag[0]);
            end
            13, 14, 15: for (int k = 0; k < n; k++)
                frag.push_back($urandom_range(1) ? 8'd32 : 8'($urandom_range(9, 13)));
            16: frag = {cf_end1, cf_end2};
            17: frag = {cf_end1};
            default: frag = {8'($urandom_range(255))};
        endcase
    endtask

    task automatic random_scans(int n_target);
        int start = n_items;
        logic [7:0] body[$];
        while (n_items - start < n_target) begin
            body.delete();
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                make_frag();
                body = {body, frag};
                if ($urandom_range(2)) body.push_back(8'd32);
            end
            if ($urandom_range(9) < 7) body = {body, cf_end1, cf_end2};
            // occasional byte between tag bodies, sent without a tag start
            if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)));
            for (int k = 0; k < body.size(); k++)
                send_byte(body[k], k == 0, k == body.size() - 1 && $urandom_range(1),
                          $urandom());
        end
    endtask

    task automatic test_directed();
        send_byte("x");                           // ignored, nothing open yet
        send_text("if a9 %]", 0, 32'hffff_fffe);
        send_text("0x1F 017 0x 1.5e+3 1e 2.e", 1, 32'h0000_0000);
        send_text("'ab\" \"q'", 1, 32'h8000_0001);
        send_text("'open", 1, 32'h1234_5678);
        send_text("12@", 0, 32'h7fff_ffff);
        send_text("ab", 0, 32'h0f0f_0f0f);
        send_text("0x.8p+2 %x %", 0, 32'h5555_aaaa);     // scan stops early at a bad byte
        send_byte(8'hff, 1, 0, 32'haaaa_5555);
        // zero byte in the middle of the text
        send_byte("w", 1, 0, 32'h0000_0100);
        send_byte(8'h00);
        send_byte("z");
    endtask

    task automatic test_delimiters();
        set_delims(8'd0, 8'd93, 4'd15);
        send_text(" a b", 1, 32'hffff_fff8);
        set_delims(8'd255, 8'd0, 4'd0);
        send_text({"ab 7", 8'hff, "q"}, 1, 32'h0000_0010);
        set_delims("#", 8'd255, 4'd7);
        send_text({"0x # #", 8'hff}, 1, 32'h0000_0020);
        random_scans(1);
        set_delims("%", "]", 4'd2);
    endtask

    task automatic test_random(int s_idle, int r_idle);
        drain();
        send_idle = s_idle;
        recv_idle = r_idle;
        random_scans(1);
    endtask

    // ---------------- result side ----------------
    always @(negedge i_clk) pop <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            n_tokens++;
            if (token_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected token kind=%0d pos=%h len=%0d fin=%b",
                             o_token_kind, o_token_pos, o_token_len, o_final_res);
            end else begin
                t_res x;
                x = token_q.pop_front();
                if (x.kind !== o_token_kind || x.pos !== o_token_pos ||
                    x.len !== o_token_len || x.fin !== o_final_res) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("token mismatch: exp %0d/%h/%0d/%b got %0d/%h/%0d/%b",
                                 x.kind, x.pos, x.len, x.fin, o_token_kind,
                                 o_token_pos, o_token_len, o_final_res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n || i_cfg_we) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d tokens pending",
                     quiet, token_q.size());
            $display("template_tag_tokenizer_tb: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        send_idle = 7;
        recv_idle = 73;
        test_directed();
        test_delimiters();
        test_random(7, 73);
        test_random(73, 7);
        test_random(0, 0);
        drain();
        if (token_q.size() != 0) n_errors++;
        $display("covered %0d bytes in %0d tags, %0d tokens checked", n_items, n_scans,
                 n_tokens);
        $display("delimiters incl. empty and one-byte forms, stalls on both sides");
        if (n_errors == 0)
            $display("template_tag_tokenizer_tb: done, clean");
        else
            $display("template_tag_tokenizer_tb: done, errors");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/ttt_pkg.sv
rtl/ttt_front.sv
rtl/ttt_fifo.sv
rtl/ttt_scan.sv
rtl/template_tag_tokenizer.sv
tb/template_tag_tokenizer_tb.sv
